>>> rtl/vtp_pkg.sv
`timescale 1ns / 1ps
package vtp_pkg;

    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 4;
    localparam int NUM_REGS = 8;
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 64;
    localparam int ADDR_W   = 6;

    // register indexes
    localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [2:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [2:0] REG_ROW3_COLS23 = 3'd7;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // what travels beside the divider lanes
    typedef struct packed {
        logic                     valid;
        logic                     div;
        logic                     sat;
        logic signed [DATA_W-1:0] res_x;
        logic signed [DATA_W-1:0] res_y;
        logic signed [DATA_W-1:0] res_z;
        logic signed [DATA_W-1:0] res_w;
    } t_sideband;

endpackage

>>> rtl/vtp_if.sv
`timescale 1ns / 1ps
interface vtp_vtx_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;

    modport source (output valid, mode, in_x, in_y, in_z, in_w, input ready);
    modport sink   (input valid, mode, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vtp_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               saturated;
    logic               divided;

    modport source (output valid, out_x, out_y, out_z, out_w, saturated, divided,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, divided,
                    output ready);
endinterface

>>> rtl/vtp_row_lane.sv
`timescale 1ns / 1ps
module vtp_row_lane
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_elem [NUM_COLS],
    input  logic signed [DATA_W-1:0] i_vec  [NUM_COLS],
    output logic signed [DATA_W-1:0] o_res,
    output logic                     o_sat
);

    localparam int SUM_W = 2 * DATA_W + 2;
    localparam logic signed [SUM_W-1:0] LIM_MAX = SUM_W'(SAT_MAX);
    localparam logic signed [SUM_W-1:0] LIM_MIN = SUM_W'(SAT_MIN);

    logic signed [2*DATA_W-1:0] r_prod [NUM_COLS];
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    floored;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                r_prod[c] <= i_elem[c] * i_vec[c];
            end
        end
    end

    // exact sum, then floor to the fraction width
    always_comb begin
        sum = '0;
        for (int c = 0; c < NUM_COLS; c++) begin
            sum = sum + SUM_W'(r_prod[c]);
        end
        floored = sum >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (floored > LIM_MAX) begin
                o_res <= SAT_MAX;
                o_sat <= 1'b1;
            end else if (floored < LIM_MIN) begin
                o_res <= SAT_MIN;
                o_sat <= 1'b1;
            end else begin
                o_res <= floored[DATA_W-1:0];
                o_sat <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/vtp_div_lane.sv
`timescale 1ns / 1ps
module vtp_div_lane
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic signed [DATA_W-1:0] o_quo,
    output logic                     o_sat
);

    // one quotient bit per stage
    localparam int NW = DATA_W + FRAC_BITS;
    localparam logic [NW-1:0] Q_NEG_LIM = NW'(64'h8000_0000);
    localparam logic [NW-1:0] Q_POS_LIM = NW'(64'h7FFF_FFFF);

    logic [DATA_W-1:0] r_rem [0:NW];
    logic [NW-1:0]     r_nq  [0:NW];
    logic [DATA_W-1:0] r_d   [0:NW];
    logic              r_neg [0:NW];

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [NW-1:0]     q;

    assign num_mag = i_num[DATA_W-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[DATA_W-1] ? (~i_den + 1'b1) : i_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_nq[0]  <= {num_mag, {FRAC_BITS{1'b0}}};
            r_d[0]   <= den_mag;
            r_neg[0] <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DATA_W:0] trial;
        logic            ge;

        assign trial = {r_rem[k], r_nq[k][NW-1]};
        assign ge    = trial >= {1'b0, r_d[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? DATA_W'(trial - {1'b0, r_d[k]}) : trial[DATA_W-1:0];
                r_nq[k+1]  <= {r_nq[k][NW-2:0], ge};
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    assign q = r_nq[NW];

    always_comb begin
        if (r_neg[NW]) begin
            o_sat = q > Q_NEG_LIM;
            o_quo = o_sat ? SAT_MIN : DATA_W'(~q + 1'b1);
        end else begin
            o_sat = q > Q_POS_LIM;
            o_quo = o_sat ? SAT_MAX : q[DATA_W-1:0];
        end
    end

endmodule

>>> rtl/vertex_transform_project_core.sv
`timescale 1ns / 1ps
// registered path: row-lane products and sums, divider input, divider stages, merge register
// one vertex per cycle unless stalled; row lanes and bit-per-stage divider are fully pipelined
// the whole pipeline advances together and stalls only while a result waits at the output
// reset (synchronous, active low) clears all valid bits and loads the identity matrix
module vertex_transform_project_core
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vtp_vtx_if.sink           i_vtx,
    vtp_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    localparam int NW = DATA_W + FRAC_BITS;
    localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

    logic [CFG_W-1:0] r_mat [NUM_REGS];
    logic [2:0]       reg_idx;

    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;
    assign prdata  = r_mat[reg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[REG_ROW0_COLS01] <= ONE;
            r_mat[REG_ROW0_COLS23] <= '0;
            r_mat[REG_ROW1_COLS01] <= ONE << 32;
            r_mat[REG_ROW1_COLS23] <= '0;
            r_mat[REG_ROW2_COLS01] <= '0;
            r_mat[REG_ROW2_COLS23] <= ONE;
            r_mat[REG_ROW3_COLS01] <= '0;
            r_mat[REG_ROW3_COLS23] <= ONE << 32;
        end else if (psel && penable && pwrite) begin
            r_mat[reg_idx] <= pwdata;
        end
    end

    logic en;
    logic r_out_valid;

    assign en          = !r_out_valid || o_res.ready;
    assign i_vtx.ready = en;

    logic                     r_v1, r_m1, r_v2, r_m2;
    logic signed [DATA_W-1:0] vec  [NUM_COLS];
    logic signed [DATA_W-1:0] res  [NUM_ROWS];
    logic                     rsat [NUM_ROWS];

    assign vec[0] = i_vtx.in_x;
    assign vec[1] = i_vtx.in_y;
    assign vec[2] = i_vtx.in_z;
    assign vec[3] = i_vtx.in_w;

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        logic signed [DATA_W-1:0] elem [NUM_COLS];
        for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
            assign elem[c] = r_mat[2*r + c/2][(c%2)*DATA_W +: DATA_W];
        end
        vtp_row_lane #(.FRAC_BITS(FRAC_BITS)) u_row (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_elem (elem),
            .i_vec  (vec),
            .o_res  (res[r]),
            .o_sat  (rsat[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_vtx.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1 <= i_vtx.mode;
            r_m2 <= r_m1;
        end
    end

    // sideband runs alongside the divider stages
    t_sideband r_sb [0:NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NW; k++) begin
                r_sb[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_sb[0].valid <= r_v2;
            r_sb[0].div   <= r_m2 && (res[3] != '0);
            r_sb[0].sat   <= rsat[0] || rsat[1] || rsat[2] || rsat[3];
            r_sb[0].res_x <= res[0];
            r_sb[0].res_y <= res[1];
            r_sb[0].res_z <= res[2];
            r_sb[0].res_w <= res[3];
            for (int k = 0; k < NW; k++) begin
                r_sb[k+1] <= r_sb[k];
            end
        end
    end

    logic signed [DATA_W-1:0] quo  [3];
    logic                     qsat [3];

    for (genvar d = 0; d < 3; d++) begin : g_div
        vtp_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (res[d]),
            .i_den (res[3]),
            .o_quo (quo[d]),
            .o_sat (qsat[d])
        );
    end

    // merge stage: pick plain or divided results and gather flags
    t_sideband last;
    assign last = r_sb[NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.out_w   <= last.res_w;
            o_res.divided <= last.div;
            if (last.div) begin
                o_res.out_x     <= quo[0];
                o_res.out_y     <= quo[1];
                o_res.out_z     <= quo[2];
                o_res.saturated <= last.sat || qsat[0] || qsat[1] || qsat[2];
            end else begin
                o_res.out_x     <= last.res_x;
                o_res.out_y     <= last.res_y;
                o_res.out_z     <= last.res_z;
                o_res.saturated <= last.sat;
            end
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

>>> rtl/vtp_checker.sv
`timescale 1ns / 1ps
module vtp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic [31:0] out_w,
    input logic        divided
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_w))
        else $error("result changed while stalled");

    // with no result waiting the pipeline must take input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // division only when w is nonzero
    a_div_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && divided |-> out_w != 32'd0)
        else $error("divided flag with zero w");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind vertex_transform_project_core vtp_checker u_vtp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_vtx.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_x     (o_res.out_x),
    .out_w     (o_res.out_w),
    .divided   (o_res.divided)
);
